[src/vcsd_pkg.sv]
// ----------------------------------------------------------------------------
// vcsd_pkg
// Shared types, identifiers, channel codes and arithmetic helpers for the
// vehicle CAN signal decoder.
// ----------------------------------------------------------------------------
package vcsd_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // register map, index = byte address / 4
    localparam logic [1:0] REG_FRAMES_EN = 2'd0;
    localparam logic [1:0] REG_BRAKE_ON  = 2'd1;
    localparam logic [1:0] REG_FUEL_CAP  = 2'd2;

    localparam logic        RST_FRAMES_EN = 1'b1;
    localparam logic [11:0] RST_BRAKE_ON  = 12'd690;
    localparam logic [7:0]  RST_FUEL_CAP  = 8'd60;

    // frame identifiers
    localparam logic [10:0] ID_WHEEL_FRONT = 11'h0A2;
    localparam logic [10:0] ID_WHEEL_REAR  = 11'h0A4;
    localparam logic [10:0] ID_STEER       = 11'h085;
    localparam logic [10:0] ID_TC_TORQUE   = 11'h0B7;
    localparam logic [10:0] ID_ENG_TORQUE  = 11'h102;
    localparam logic [10:0] ID_DRIVETRAIN  = 11'h114;
    localparam logic [10:0] ID_FUEL_TEMP   = 11'h400;
    localparam logic [10:0] ID_DYNAMICS    = 11'h303;

    // channel codes
    localparam logic [4:0] CH_WHEEL_LF = 5'd0;
    localparam logic [4:0] CH_WHEEL_RF = 5'd1;
    localparam logic [4:0] CH_WHEEL_LR = 5'd2;
    localparam logic [4:0] CH_WHEEL_RR = 5'd3;
    localparam logic [4:0] CH_BRAKE    = 5'd4;
    localparam logic [4:0] CH_STEER    = 5'd5;
    localparam logic [4:0] CH_TC_TQ    = 5'd6;
    localparam logic [4:0] CH_ENG_TQ   = 5'd7;
    localparam logic [4:0] CH_SPORT    = 5'd8;
    localparam logic [4:0] CH_TC_OFF   = 5'd9;
    localparam logic [4:0] CH_CLUTCH   = 5'd10;
    localparam logic [4:0] CH_TPS      = 5'd11;
    localparam logic [4:0] CH_RPM      = 5'd12;
    localparam logic [4:0] CH_FUEL     = 5'd13;
    localparam logic [4:0] CH_TEMP     = 5'd14;
    localparam logic [4:0] CH_LAT_G    = 5'd15;
    localparam logic [4:0] CH_YAW      = 5'd16;

    localparam logic [13:0] WHEEL_INVALID = 14'h3FFF;
    localparam logic [11:0] TC_INVALID    = 12'hFFF;

    // lateral g: round((L*63491 + 132812) / 265625) folded into one product
    localparam logic [63:0] LatDiv     = 64'd265625;
    localparam logic [63:0] LAT_RECIP  = ((64'd1 << 46) + LatDiv - 64'd1) / LatDiv;
    localparam logic [63:0] LAT_MUL    = LAT_RECIP * 64'd63491;
    localparam logic [63:0] LAT_ROUND  = LAT_RECIP * 64'd132812;

    typedef struct packed {
        logic [10:0] can_id;
        logic [3:0]  frame_length;
        logic [63:0] frame_data;
    } frame_t;

    typedef struct packed {
        logic [4:0]  channel;
        logic [31:0] value;
    } result_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        result_t [MAX_RESULTS-1:0]    res;
    } result_set_t;

    typedef struct packed {
        logic        frames_en;
        logic [11:0] brake_on;
        logic [7:0]  fuel_cap;
    } cfg_t;

    // floor(y / 255) for y below 65535
    function automatic logic [8:0] div255(input logic [15:0] y);
        logic [16:0] s;
        s = {1'b0, y} + {9'b0, y[15:8]} + 17'd1;
        return s[16:8];
    endfunction

endpackage

[src/vcsd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// vcsd_cfg_regs
// APB configuration registers: frame enable, brake level, fuel tank size.
// ----------------------------------------------------------------------------
module vcsd_cfg_regs
    import vcsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic        frames_en_reg;
    logic [11:0] brake_on_reg;
    logic [7:0]  fuel_cap_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_en_reg <= RST_FRAMES_EN;
            brake_on_reg  <= RST_BRAKE_ON;
            fuel_cap_reg  <= RST_FUEL_CAP;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRAMES_EN: frames_en_reg <= pwdata[0];
                REG_BRAKE_ON:  brake_on_reg  <= pwdata[11:0];
                REG_FUEL_CAP:  fuel_cap_reg  <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAMES_EN: prdata = {31'b0, frames_en_reg};
            REG_BRAKE_ON:  prdata = {20'b0, brake_on_reg};
            REG_FUEL_CAP:  prdata = {24'b0, fuel_cap_reg};
            default:       prdata = 32'b0;
        endcase
    end

    assign cfg = '{frames_en: frames_en_reg, brake_on: brake_on_reg,
                   fuel_cap: fuel_cap_reg};

endmodule

[src/vcsd_decode.sv]
// ----------------------------------------------------------------------------
// vcsd_decode
// Frame layout select, length check, field extraction and Q16.16 scaling.
// ----------------------------------------------------------------------------
module vcsd_decode
    import vcsd_pkg::*;
(
    input  frame_t      frame,
    input  cfg_t        cfg,
    output result_set_t set
);

    logic [7:0]         b0, b1, b2, b3, b4, b5, b6;
    logic [13:0]        wheel_a, wheel_b;
    logic [31:0]        wheel_a_q, wheel_b_q, brake_q;

    logic signed [15:0] steer_raw;
    logic               steer_ok;
    logic [11:0]        steer_abs;
    logic [14:0]        steer_rem;
    logic [31:0]        steer_prod;
    logic [24:0]        steer_mag;
    logic [31:0]        steer_q;

    logic [11:0]        tc_raw, tc_bias;
    logic signed [10:0] tc_val;

    logic [9:0]         eng_val;
    logic [8:0]         tps_val;
    logic [13:0]        rpm_val;

    logic [15:0]        fuel_prod;
    logic [24:0]        fuel_mag;
    logic [11:0]        temp_prod;
    logic signed [9:0]  temp_val;

    logic signed [12:0] lat, yaw;
    logic [11:0]        lat_abs;
    logic [63:0]        lat_prod;
    logic [14:0]        lat_mag;
    logic [31:0]        lat_q;

    assign b0 = frame.frame_data[7:0];
    assign b1 = frame.frame_data[15:8];
    assign b2 = frame.frame_data[23:16];
    assign b3 = frame.frame_data[31:24];
    assign b4 = frame.frame_data[39:32];
    assign b5 = frame.frame_data[47:40];
    assign b6 = frame.frame_data[55:48];

    // wheel speeds, raw/16 km/h
    assign wheel_a   = {b1[5:0], b0};
    assign wheel_b   = {b3[3:0], b2, b1[7:6]};
    assign wheel_a_q = (wheel_a == WHEEL_INVALID) ? 32'b0 : {6'b0, wheel_a, 12'b0};
    assign wheel_b_q = (wheel_b == WHEEL_INVALID) ? 32'b0 : {6'b0, wheel_b, 12'b0};
    assign brake_q   = (b4[1:0] != 2'b0) ? {4'b0, cfg.brake_on, 16'b0} : 32'b0;

    // steering, raw/10 degrees: |v|*6553 + round(6|v|/10)
    assign steer_raw  = $signed({b1, b0});
    assign steer_ok   = (steer_raw > -16'sd3600) && (steer_raw < 16'sd3600);
    assign steer_abs  = steer_raw[15] ? 12'(-steer_raw) : steer_raw[11:0];
    assign steer_rem  = 15'(steer_abs) * 15'd6 + 15'd5;
    assign steer_prod = 32'(steer_rem) * 32'd52429;
    assign steer_mag  = 25'(steer_abs) * 25'd6553 + 25'(steer_prod[31:19]);
    assign steer_q    = steer_raw[15] ? -{7'b0, steer_mag} : {7'b0, steer_mag};

    // stability torque request
    assign tc_raw  = {b2, b1[7:4]};
    assign tc_bias = tc_raw ^ 12'h800;
    assign tc_val  = (tc_raw == TC_INVALID) ? 11'sd911
                   : $signed({1'b0, tc_bias[11:2]}) - 11'sd112;

    assign eng_val = {b1[3:0], b0[7:2]};
    assign tps_val = div255(16'(b3) * 16'd100);
    assign rpm_val = {b1, b0[7:2]};

    // fuel: round(p*65536/255) = p*257 + floor((p+127)/255)
    assign fuel_prod = 16'(b4) * 16'(cfg.fuel_cap);
    assign fuel_mag  = 25'(fuel_prod) * 25'd257 + 25'(div255(fuel_prod + 16'd127));
    assign temp_prod = 12'(b5) * 12'd9;
    assign temp_val  = $signed({1'b0, temp_prod[11:3]}) - 10'sd40;

    // lateral acceleration and yaw
    assign lat      = $signed({1'b0, b4, b5[7:4]}) - 13'sd2049;
    assign lat_abs  = lat[12] ? 12'(-lat) : lat[11:0];
    assign lat_prod = 64'(lat_abs) * LAT_MUL + LAT_ROUND;
    assign lat_mag  = 15'(lat_abs) * 15'd5 + 15'(lat_prod[63:46]);
    assign lat_q    = lat[12] ? -{17'b0, lat_mag} : {17'b0, lat_mag};
    assign yaw      = $signed({1'b0, b5[3:0], b6}) - 13'sd2048;

    always_comb
    begin
        set = '0;
        if (cfg.frames_en)
        begin
            unique case (frame.can_id)
                ID_WHEEL_FRONT:
                    if (frame.frame_length >= 4'd6)
                    begin
                        set.res[0] = '{CH_WHEEL_LF, wheel_a_q};
                        set.res[1] = '{CH_WHEEL_RF, wheel_b_q};
                        set.count  = RES_CNT_W'(2);
                    end
                ID_WHEEL_REAR:
                    if (frame.frame_length >= 4'd5)
                    begin
                        set.res[0] = '{CH_WHEEL_LR, wheel_a_q};
                        set.res[1] = '{CH_WHEEL_RR, wheel_b_q};
                        set.res[2] = '{CH_BRAKE, brake_q};
                        set.count  = RES_CNT_W'(3);
                    end
                ID_STEER:
                    if (frame.frame_length >= 4'd3 && steer_ok)
                    begin
                        set.res[0] = '{CH_STEER, steer_q};
                        set.count  = RES_CNT_W'(1);
                    end
                ID_TC_TORQUE:
                    if (frame.frame_length >= 4'd3)
                    begin
                        set.res[0] = '{CH_TC_TQ, {{5{tc_val[10]}}, tc_val, 16'b0}};
                        set.count  = RES_CNT_W'(1);
                    end
                ID_ENG_TORQUE:
                    if (frame.frame_length >= 4'd3)
                    begin
                        set.res[0] = '{CH_ENG_TQ, {6'b0, eng_val, 16'b0}};
                        set.count  = RES_CNT_W'(1);
                    end
                ID_DRIVETRAIN:
                    if (frame.frame_length >= 4'd6)
                    begin
                        set.res[0] = '{CH_SPORT, {15'b0, b4[7], 16'b0}};
                        set.res[1] = '{CH_TC_OFF, {15'b0, b4[6], 16'b0}};
                        set.res[2] = '{CH_CLUTCH, {14'b0, b4[5:4], 16'b0}};
                        set.res[3] = '{CH_TPS, {7'b0, tps_val, 16'b0}};
                        set.res[4] = '{CH_RPM, {2'b0, rpm_val, 16'b0}};
                        set.count  = RES_CNT_W'(5);
                    end
                ID_FUEL_TEMP:
                    if (frame.frame_length >= 4'd6)
                    begin
                        set.res[0] = '{CH_FUEL, {7'b0, fuel_mag}};
                        set.res[1] = '{CH_TEMP, {{6{temp_val[9]}}, temp_val, 16'b0}};
                        set.count  = RES_CNT_W'(2);
                    end
                ID_DYNAMICS:
                    if (frame.frame_length >= 4'd7)
                    begin
                        set.res[0] = '{CH_LAT_G, lat_q};
                        set.res[1] = '{CH_YAW, {yaw, 19'b0}};
                        set.count  = RES_CNT_W'(2);
                    end
                default: ;
            endcase
        end
    end

endmodule

[src/vcsd_result_buf.sv]
// ----------------------------------------------------------------------------
// vcsd_result_buf
// Holds the results of one frame and sends them out one per transfer.
// ----------------------------------------------------------------------------
module vcsd_result_buf
    import vcsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  result_set_t set,
    output logic        load,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value[31:0]
    output logic [4:0]  m_axis_tuser,   // channel[4:0]
    output logic        m_axis_tlast
);

    result_t [MAX_RESULTS-1:0] res_reg;
    logic [RES_CNT_W-1:0]      rem_reg;
    logic                      take;

    assign m_axis_tvalid = (rem_reg != '0);
    assign take          = m_axis_tvalid && m_axis_tready;
    assign load          = in_valid && (!m_axis_tvalid ||
                                        (take && rem_reg == RES_CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (load)
        begin
            rem_reg <= set.count;
        end
        else if (take)
        begin
            rem_reg <= rem_reg - RES_CNT_W'(1);
        end
    end

    // advance the queue on each transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= set.res;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_reg[i] <= res_reg[i+1];
            end
            res_reg[MAX_RESULTS-1] <= '0;
        end
    end

    assign m_axis_tdata = res_reg[0].value;
    assign m_axis_tuser = res_reg[0].channel;
    assign m_axis_tlast = (rem_reg == RES_CNT_W'(1));

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result count out of range");

    a_rem_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !load) |=> (rem_reg == $past(rem_reg) - RES_CNT_W'(1)))
        else $error("result count did not advance on transfer");

    a_rem_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (rem_reg == $past(set.count)))
        else $error("result count not loaded from decoded frame");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !load)
        else $error("pending results overwritten");

endmodule

[src/vehicle_can_signal_decoder.sv]
// ----------------------------------------------------------------------------
// vehicle_can_signal_decoder
// Decodes vehicle CAN frames into Q16.16 channel/value results.
// ----------------------------------------------------------------------------
// A frame is taken into an input register, decoded by short combinational
// logic and loaded into a result buffer, which sends its zero to five
// results one per cycle while m_axis_tready is high, tlast on the final one.
// The sustained frame rate is set by the single output port of the result
// buffer, since a frame holds the output until all its results are taken.
// A frame waiting in the input register is loaded in the cycle the last
// result ahead of it is taken, and the next frame is accepted in that same
// cycle.
// ----------------------------------------------------------------------------
module vehicle_can_signal_decoder
    import vcsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // can_id[10:0], frame_length[14:11],
                                        // frame_data[78:15], zero pad [79]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value[31:0]
    output logic [4:0]  m_axis_tuser,   // channel[4:0]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    frame_t      frame_reg;
    logic        in_vld_reg;
    logic        load;
    cfg_t        cfg;
    result_set_t set;

    assign s_axis_tready = !in_vld_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (load)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            frame_reg.can_id       <= s_axis_tdata[10:0];
            frame_reg.frame_length <= s_axis_tdata[14:11];
            frame_reg.frame_data   <= s_axis_tdata[78:15];
        end
    end

    vcsd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vcsd_decode u_decode (
        .frame (frame_reg),
        .cfg   (cfg),
        .set   (set)
    );

    vcsd_result_buf u_result_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_vld_reg),
        .set           (set),
        .load          (load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
